FILE: design/shrp_pkg.sv
// shared constants and types for the 3x3 sharpening filter
// no dependencies

package shrp_pkg;

   localparam int MAX_WIDTH    = 2048;
   localparam int MAX_CHANNELS = 4;
   localparam int LINE_DEPTH   = MAX_WIDTH * MAX_CHANNELS;
   localparam int WIN_DEPTH    = 3 * MAX_CHANNELS;

   localparam int SMP_W  = 8;
   localparam int WDT_W  = 12;
   localparam int HGT_W  = 12;
   localparam int CHN_W  = 3;
   localparam int COL_W  = $clog2(LINE_DEPTH);
   localparam int LEN_W  = $clog2(LINE_DEPTH + 1);
   localparam int POS_W  = COL_W + HGT_W;
   localparam int PEND_W = $clog2(LINE_DEPTH + MAX_CHANNELS + 2);
   localparam int DIVC_W = $clog2(POS_W);
   localparam int WIN_IW = $clog2(WIN_DEPTH + 1);

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   typedef logic [SMP_W-1:0]      sample_type;
   typedef logic [CSR_IDX_W-1:0]  csr_index_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;

   localparam csr_index_type REG_WIDTH    = 2'd0;
   localparam csr_index_type REG_HEIGHT   = 2'd1;
   localparam csr_index_type REG_CHANNELS = 2'd2;

   localparam logic [WDT_W-1:0] WIDTH_RST    = 12'd640;
   localparam logic [HGT_W-1:0] HEIGHT_RST   = 12'd480;
   localparam logic [CHN_W-1:0] CHANNELS_RST = 3'd3;

endpackage

FILE: design/sharpen_3x3_filter.sv
// 3x3 cross-kernel sharpening filter for channel-interleaved raster streams
// depends on shrp_pkg
//
// req channel: one 8-bit sample word per accepted cycle, in raster order,
//   channels interleaved per pixel; req_flush words carry no sample and
//   only push the pipeline so the tail of the last frame drains
// rsp channel: sharpened words in raster order, zero on the frame border,
//   rsp_last on the final word of each frame
// csr channel: width, height and channel count, always ready
// results lag the input by one row plus one pixel (W*C + C words); the word
//   that releases a result is registered in the window stage and then in the output register
// throughput is one word per cycle unless rsp_stall holds a result, set by the single
//   line buffer port pair read on accept and written as the word leaves the window stage
// after reset and after every csr write the block steps through SEQ_GEOM,
//   SEQ_FRAME, SEQ_LOAD and SEQ_DIV, recomputing frame geometry and splitting
//   the output position into row and column with a bit-serial divider;
//   req_stall is high meanwhile
// when rsp_stall holds a result, the word behind it waits in the window stage
//   and req_stall rises only if that word also has a result to deliver

module sharpen_3x3_filter (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  shrp_pkg::sample_type   req_sample,
   input  logic                   req_flush,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output shrp_pkg::sample_type   rsp_value,
   output logic                   rsp_last,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  shrp_pkg::csr_index_type csr_index,
   input  shrp_pkg::csr_data_type  csr_data
);
   import shrp_pkg::*;

   localparam logic [2:0] SEQ_GEOM  = 3'd0;
   localparam logic [2:0] SEQ_FRAME = 3'd1;
   localparam logic [2:0] SEQ_LOAD  = 3'd2;
   localparam logic [2:0] SEQ_DIV   = 3'd3;
   localparam logic [2:0] SEQ_RUN   = 3'd4;

   // configuration and derived geometry
   logic [WDT_W-1:0]  cfg_width_ff;
   logic [HGT_W-1:0]  cfg_height_ff;
   logic [CHN_W-1:0]  cfg_chan_ff;
   logic [CHN_W-1:0]  c_ff;
   logic [HGT_W-1:0]  h_ff;
   logic [LEN_W-1:0]  len_ff;
   logic [LEN_W:0]    lc_ff;
   logic [POS_W-1:0]  frame_ff;
   logic [LEN_W-1:0]  w_eff;
   logic [CHN_W-1:0]  c_eff;
   logic [HGT_W-1:0]  h_eff;

   // sequencer and divider
   logic [2:0]        seq_ff, seq_in;
   logic [DIVC_W-1:0] div_cnt_ff;
   logic [POS_W-1:0]  dvd_ff;
   logic [COL_W-1:0]  rem_ff;
   logic [HGT_W-1:0]  quo_ff;
   logic [LEN_W-1:0]  div_trial;
   logic              div_ge;
   logic [COL_W-1:0]  rem_in;
   logic [HGT_W-1:0]  quo_in;

   // input side counters
   logic [COL_W-1:0]  incol_ff, incol_in;
   logic [PEND_W-1:0] pend_ff, pend_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [COL_W-1:0]  ox_ff, ox_in;
   logic [HGT_W-1:0]  orow_ff, orow_in;

   logic              a_fire;
   logic [COL_W-1:0]  col_a;
   logic [LEN_W-1:0]  col_inc;
   logic [PEND_W:0]   pend_inc;
   logic              emit_a;
   logic              border_a;
   logic              last_a;
   logic [POS_W-1:0]  pos_a;
   logic [LEN_W:0]    ox_inc;
   logic [HGT_W:0]    orow_inc;
   logic [POS_W:0]    pos_inc;

   // window stage
   logic              s1_valid_ff, s1_valid_in;
   sample_type        s1_sample_ff;
   logic [COL_W-1:0]  s1_col_ff;
   logic              s1_emit_ff;
   logic              s1_border_ff;
   logic              s1_last_ff;
   logic              s1_fwd_ff;
   logic              s1_go;
   logic              b_fire;

   sample_type        line_centre_mem [LINE_DEPTH];
   sample_type        line_above_mem  [LINE_DEPTH];
   sample_type        rd_right_ff;
   sample_type        rd_above_ff;
   sample_type        fwd_right_ff;
   sample_type        fwd_above_ff;

   sample_type        win_ff [WIN_DEPTH];
   sample_type        win_in [WIN_DEPTH];
   logic [WIN_IW-1:0] c_win;
   logic [WIN_IW-1:0] c3_win;

   sample_type        t_right, t_above, t_below, t_centre, t_left;
   logic [11:0]       five_c;
   logic [11:0]       neigh;
   logic signed [11:0] diff;
   sample_type        sharp;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   sample_type        rsp_value_ff;
   logic              rsp_last_ff;

   // geometry clamping
   always_comb begin
      priority if (cfg_width_ff == '0) begin
         w_eff = LEN_W'(1);
      end else if (int'(cfg_width_ff) > MAX_WIDTH) begin
         w_eff = LEN_W'(MAX_WIDTH);
      end else begin
         w_eff = LEN_W'(cfg_width_ff);
      end
      priority if (cfg_chan_ff == '0) begin
         c_eff = CHN_W'(1);
      end else if (int'(cfg_chan_ff) > MAX_CHANNELS) begin
         c_eff = CHN_W'(MAX_CHANNELS);
      end else begin
         c_eff = cfg_chan_ff;
      end
      h_eff = (cfg_height_ff == '0) ? HGT_W'(1) : cfg_height_ff;
   end

   // bit-serial divide of the output position by the row length
   always_comb begin
      div_trial = {rem_ff, dvd_ff[POS_W-1]};
      div_ge    = div_trial >= len_ff;
      rem_in    = div_ge ? COL_W'(div_trial - len_ff) : COL_W'(div_trial);
      quo_in    = {quo_ff[HGT_W-2:0], div_ge};
   end

   always_comb begin
      seq_in = seq_ff;
      unique case (seq_ff)
         SEQ_GEOM:  seq_in = SEQ_FRAME;
         SEQ_FRAME: seq_in = SEQ_LOAD;
         SEQ_LOAD:  seq_in = SEQ_DIV;
         SEQ_DIV:   seq_in = (div_cnt_ff == DIVC_W'(POS_W - 1)) ? SEQ_RUN : SEQ_DIV;
         SEQ_RUN:   seq_in = SEQ_RUN;
         default:   seq_in = SEQ_GEOM;
      endcase
      if (csr_valid && csr_ready) begin
         seq_in = SEQ_GEOM;
      end
   end

   assign csr_ready = 1'b1;

   // handshake
   assign s1_go     = !s1_emit_ff || !rsp_valid_ff || !rsp_stall;
   assign req_stall = (seq_ff != SEQ_RUN) || (s1_valid_ff && !s1_go);
   assign a_fire    = req_valid && !req_stall;
   assign b_fire    = s1_valid_ff && s1_go;

   // input stage: address, pending count, output position
   always_comb begin
      col_a    = (LEN_W'(incol_ff) >= len_ff) ? '0 : incol_ff;
      col_inc  = LEN_W'(col_a) + LEN_W'(1);
      incol_in = incol_ff;
      if (a_fire) begin
         incol_in = (col_inc >= len_ff) ? '0 : COL_W'(col_inc);
      end

      pend_inc = (PEND_W + 1)'(pend_ff) + (PEND_W + 1)'(1);
      pend_in  = pend_ff;
      if (req_flush) begin
         emit_a = pend_ff != '0;
         if (a_fire && emit_a) begin
            pend_in = pend_ff - PEND_W'(1);
         end
      end else begin
         emit_a = pend_inc > (PEND_W + 1)'(lc_ff);
         if (a_fire && !emit_a) begin
            pend_in = PEND_W'(pend_inc);
         end
      end

      pos_a    = (pos_ff >= frame_ff) ? '0 : pos_ff;
      ox_inc   = (LEN_W + 1)'(ox_ff) + (LEN_W + 1)'(1);
      orow_inc = (HGT_W + 1)'(orow_ff) + (HGT_W + 1)'(1);
      pos_inc  = (POS_W + 1)'(pos_a) + (POS_W + 1)'(1);
      border_a = (orow_ff == '0) || (orow_inc >= (HGT_W + 1)'(h_ff))
                 || ((LEN_W + 1)'(ox_ff) < (LEN_W + 1)'(c_ff))
                 || ((LEN_W + 1)'(ox_ff) + (LEN_W + 1)'(c_ff) >= (LEN_W + 1)'(len_ff));
      last_a   = pos_inc == (POS_W + 1)'(frame_ff);

      pos_in  = pos_ff;
      ox_in   = ox_ff;
      orow_in = orow_ff;
      if (a_fire && emit_a) begin
         pos_in = (pos_inc >= (POS_W + 1)'(frame_ff)) ? '0 : POS_W'(pos_inc);
         if (ox_inc >= (LEN_W + 1)'(len_ff)) begin
            ox_in   = '0;
            orow_in = (orow_inc >= (HGT_W + 1)'(h_ff)) ? '0 : HGT_W'(orow_inc);
         end else begin
            ox_in = COL_W'(ox_inc);
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (a_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
   end

   // window taps and shift
   always_comb begin
      t_right  = s1_fwd_ff ? fwd_right_ff : rd_right_ff;
      t_above  = s1_fwd_ff ? fwd_above_ff : rd_above_ff;
      t_below  = win_ff[0];
      t_centre = win_ff[1];
      t_left   = win_ff[2];
      for (int k = 1; k <= MAX_CHANNELS; k++) begin
         if (c_ff == CHN_W'(k)) begin
            t_below  = win_ff[k - 1];
            t_centre = win_ff[2 * k - 1];
            t_left   = win_ff[3 * k - 1];
         end
      end

      c_win  = WIN_IW'(c_ff);
      c3_win = c_win + c_win + c_win;
      for (int j = 0; j < WIN_DEPTH; j++) begin
         win_in[j] = win_ff[j];
      end
      if (b_fire) begin
         win_in[0] = s1_sample_ff;
         for (int j = 1; j < WIN_DEPTH; j++) begin
            priority if (WIN_IW'(j) < c_win) begin
               win_in[j] = win_ff[j - 1];
            end else if (WIN_IW'(j) == c_win) begin
               win_in[j] = t_right;
            end else if (WIN_IW'(j) < c3_win) begin
               win_in[j] = win_ff[j - 1];
            end else begin
               win_in[j] = win_ff[j];
            end
         end
      end
   end

   // kernel and saturation
   always_comb begin
      five_c = {2'b00, t_centre, 2'b00} + {4'b0000, t_centre};
      neigh  = {4'b0000, t_above} + {4'b0000, t_below}
               + {4'b0000, t_left} + {4'b0000, t_right};
      diff   = signed'(five_c) - signed'(neigh);
      priority if (diff < 0) begin
         sharp = '0;
      end else if (diff > 12'sd255) begin
         sharp = '1;
      end else begin
         sharp = diff[SMP_W-1:0];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (b_fire && s1_emit_ff) begin
         rsp_valid_in = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff  <= WIDTH_RST;
         cfg_height_ff <= HEIGHT_RST;
         cfg_chan_ff   <= CHANNELS_RST;
         seq_ff        <= SEQ_GEOM;
         c_ff          <= CHANNELS_RST;
         h_ff          <= HEIGHT_RST;
         len_ff        <= LEN_W'(1);
         lc_ff         <= (LEN_W + 1)'(1);
         frame_ff      <= POS_W'(1);
         div_cnt_ff    <= '0;
         incol_ff      <= '0;
         pend_ff       <= '0;
         pos_ff        <= '0;
         ox_ff         <= '0;
         orow_ff       <= '0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int j = 0; j < WIN_DEPTH; j++) begin
            win_ff[j] <= '0;
         end
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               REG_WIDTH:    cfg_width_ff  <= csr_data;
               REG_HEIGHT:   cfg_height_ff <= csr_data;
               REG_CHANNELS: cfg_chan_ff   <= csr_data[CHN_W-1:0];
               default: ;
            endcase
         end
         seq_ff <= seq_in;
         unique case (seq_ff)
            SEQ_GEOM: begin
               c_ff   <= c_eff;
               h_ff   <= h_eff;
               len_ff <= LEN_W'(w_eff * c_eff);
            end
            SEQ_FRAME: begin
               frame_ff <= POS_W'(len_ff * h_ff);
               lc_ff    <= (LEN_W + 1)'(len_ff) + (LEN_W + 1)'(c_ff);
            end
            SEQ_LOAD: begin
               dvd_ff     <= (pos_ff >= frame_ff) ? '0 : pos_ff;
               rem_ff     <= '0;
               quo_ff     <= '0;
               div_cnt_ff <= '0;
            end
            SEQ_DIV: begin
               dvd_ff     <= dvd_ff << 1;
               rem_ff     <= rem_in;
               quo_ff     <= quo_in;
               div_cnt_ff <= div_cnt_ff + DIVC_W'(1);
               if (div_cnt_ff == DIVC_W'(POS_W - 1)) begin
                  ox_ff   <= rem_in;
                  orow_ff <= quo_in;
               end
            end
            SEQ_RUN: begin
               pos_ff  <= pos_in;
               ox_ff   <= ox_in;
               orow_ff <= orow_in;
            end
            default: ;
         endcase
         incol_ff     <= incol_in;
         pend_ff      <= pend_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int j = 0; j < WIN_DEPTH; j++) begin
            win_ff[j] <= win_in[j];
         end
      end
   end

   // window stage payload
   always_ff @(posedge clock) begin
      if (a_fire) begin
         s1_sample_ff <= req_flush ? '0 : req_sample;
         s1_col_ff    <= col_a;
         s1_emit_ff   <= emit_a;
         s1_border_ff <= border_a;
         s1_last_ff   <= last_a;
         s1_fwd_ff    <= s1_valid_ff && (s1_col_ff == col_a);
      end
      if (b_fire) begin
         fwd_right_ff <= s1_sample_ff;
         fwd_above_ff <= t_centre;
      end
      if (b_fire && s1_emit_ff) begin
         rsp_value_ff <= s1_border_ff ? '0 : sharp;
         rsp_last_ff  <= s1_last_ff;
      end
   end

   // line buffers
   always_ff @(posedge clock) begin
      if (a_fire) begin
         rd_right_ff <= line_centre_mem[col_a];
         rd_above_ff <= line_above_mem[col_a];
      end
      if (b_fire) begin
         line_centre_mem[s1_col_ff] <= s1_sample_ff;
         line_above_mem[s1_col_ff]  <= t_centre;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;
   assign rsp_last  = rsp_last_ff;

   assert property (@(posedge clock) disable iff (reset)
      (seq_ff != SEQ_RUN) |-> req_stall)
      else $error("word accepted during geometry update");

   assert property (@(posedge clock) disable iff (reset)
      (seq_ff == SEQ_RUN) |-> ((LEN_W'(ox_ff) < len_ff) && (orow_ff < h_ff)))
      else $error("output row or column out of range");

   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_fwd_ff) |-> (len_ff == LEN_W'(1)))
      else $error("line buffer bypass with row longer than one word");

   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_go) |-> (s1_emit_ff && rsp_valid_ff && rsp_stall))
      else $error("window stage held without a blocked result");

endmodule
